@@ rtl/mts_pkg.sv @@
// Shared types and constants of the multipath transport selector.
package mts_pkg;

   // Request kinds carried in req_type
   localparam logic [1:0] REQ_HEARD  = 2'd0;
   localparam logic [1:0] REQ_UP     = 2'd1;
   localparam logic [1:0] REQ_DOWN   = 2'd2;
   localparam logic [1:0] REQ_CHOOSE = 2'd3;

   // Notice kinds carried in notice_kind
   localparam logic [1:0] NOTICE_NONE        = 2'd0;
   localparam logic [1:0] NOTICE_AVAILABLE   = 2'd1;
   localparam logic [1:0] NOTICE_UNREACHABLE = 2'd2;

   // Configuration register indexes
   localparam logic CSR_PATH_COUNT = 1'b0;
   localparam logic CSR_PRIMARY    = 1'b1;

   localparam int PATH_BITS  = 3;
   localparam int COUNT_BITS = 4;
   localparam int ERROR_BITS = 16;
   localparam int STAMP_BITS = 32;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [PATH_BITS-1:0]  path_index;
      logic [STAMP_BITS-1:0] timestamp;
      logic [ERROR_BITS-1:0] error_code;
   } req_item_type;

   typedef struct packed {
      logic [PATH_BITS-1:0]  tx_path;
      logic [PATH_BITS-1:0]  rtx_path;
      logic [PATH_BITS-1:0]  shutdown_path;
      logic [1:0]            notice_kind;
      logic [ERROR_BITS-1:0] notice_error;
   } rsp_item_type;

   // Table update broadcast to every cell
   typedef struct packed {
      logic                 en;
      logic [PATH_BITS-1:0] idx;
      logic                 set_time;
      logic                 set_act;
      logic                 act;
   } wr_ctl_type;

   // Running picks handed from cell to cell (times travel beside it)
   typedef struct packed {
      logic                 have1;
      logic [PATH_BITS-1:0] first;
      logic                 have2;
      logic [PATH_BITS-1:0] second;
      logic                 found_after;
      logic [PATH_BITS-1:0] idx_after;
      logic                 found_wrap;
      logic [PATH_BITS-1:0] idx_wrap;
   } chain_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/mts_cell.sv @@
// One path cell: holds the path's flag and last-heard time and refines the running picks.
module mts_cell #(
   parameter int TIME_BITS  = 32,
   parameter int CELL_INDEX = 0
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  mts_pkg::wr_ctl_type                        wr,
   input  logic [TIME_BITS-1:0]                       wr_time,
   input  logic [mts_pkg::COUNT_BITS-1:0]             path_n,
   input  logic [mts_pkg::PATH_BITS-1:0]              start,
   input  mts_pkg::chain_ctl_type                     in_ctl,
   input  logic [TIME_BITS-1:0]                       in_t1,
   input  logic [TIME_BITS-1:0]                       in_t2,
   output mts_pkg::chain_ctl_type                     out_ctl,
   output logic [TIME_BITS-1:0]                       out_t1,
   output logic [TIME_BITS-1:0]                       out_t2,
   output logic                                       active_out
);

   localparam logic [mts_pkg::PATH_BITS-1:0] MY_IDX = mts_pkg::PATH_BITS'(CELL_INDEX);

   logic                   active_ff;
   logic [TIME_BITS-1:0]   time_ff;
   mts_pkg::chain_ctl_type ctl_ff, ctl_in;
   logic [TIME_BITS-1:0]   t1_ff, t1_in, t2_ff, t2_in;
   logic                   live;
   logic                   hit;

   assign hit  = wr.en && (wr.idx == MY_IDX);
   assign live = active_ff && ({1'b0, MY_IDX} < path_n);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         time_ff   <= '0;
      end else if (hit) begin
         if (wr.set_act) begin
            active_ff <= wr.act;
         end
         if (wr.set_time) begin
            time_ff <= wr_time;
         end
      end
   end

   always_comb begin
      ctl_in = in_ctl;
      t1_in  = in_t1;
      t2_in  = in_t2;
      if (live) begin
         // best-two ranking, ties keep the lower index
         if (!in_ctl.have1 || (time_ff > in_t1)) begin
            ctl_in.second = in_ctl.first;
            ctl_in.have2  = in_ctl.have1;
            t2_in         = in_t1;
            ctl_in.first  = MY_IDX;
            ctl_in.have1  = 1'b1;
            t1_in         = time_ff;
         end else if (!in_ctl.have2 || (time_ff > in_t2)) begin
            ctl_in.second = MY_IDX;
            ctl_in.have2  = 1'b1;
            t2_in         = time_ff;
         end
         // round-robin search: first active after start, else first up to start
         if ((MY_IDX > start) && !in_ctl.found_after) begin
            ctl_in.found_after = 1'b1;
            ctl_in.idx_after   = MY_IDX;
         end
         if ((MY_IDX <= start) && !in_ctl.found_wrap) begin
            ctl_in.found_wrap = 1'b1;
            ctl_in.idx_wrap   = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      t1_ff <= t1_in;
      t2_ff <= t2_in;
   end

   assign out_ctl    = ctl_ff;
   assign out_t1     = t1_ff;
   assign out_t2     = t2_ff;
   assign active_out = active_ff;

endmodule

@@ rtl/multipath_transport_selector.sv @@
// Top level of the multipath transport selector: request control, path cell row and result register.
//
// Usage:
//   req_* carries one request (heard, path up, path down, choose shutdown path); it is
//   taken at a clock edge with req_valid high and req_stall low. Every request yields
//   exactly one response on rsp_*, taken at an edge with rsp_valid high and rsp_stall low.
//   csr_* writes path_count (index 0) and primary_index (index 1); write only while idle.
// Timing:
//   the path table lives in a row of min(MAX_PATHS, 8) cells. After a request is taken
//   the running picks ripple one cell per cycle, and its response is registered once the
//   last cell holds picks built from the updated table; one request is in work at a time.
//   The response register lets a new request be taken while the previous response
//   still waits on rsp_stall.
// Reset:
//   synchronous and active high; all paths active, all last-heard times zero, active,
//   retransmit and last shutdown path 0, path_count 1, primary_index 0, no response.
// Stall:
//   a stalled response holds its payload; a finished request waits in its final state
//   until the response register frees, and req_stall stays high meanwhile.
module multipath_transport_selector #(
   parameter int MAX_PATHS = 8,
   parameter int TIME_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mts_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mts_pkg::rsp_item_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);

   localparam int PATH_LIMIT = (MAX_PATHS < 8) ? MAX_PATHS : 8;
   localparam int CNT_BITS   = (PATH_LIMIT > 1) ? $clog2(PATH_LIMIT) : 1;
   localparam int PB         = mts_pkg::PATH_BITS;
   localparam int CB         = mts_pkg::COUNT_BITS;

   // configuration
   logic [CB-1:0] path_count_ff;
   logic [PB-1:0] primary_ff;

   // selection state
   logic [PB-1:0] cur_active_ff, cur_active_in;
   logic [PB-1:0] cur_retran_ff, cur_retran_in;
   logic [PB-1:0] last_shut_ff, last_shut_in;
   logic          shut_sent_ff, shut_sent_in;

   // request in work
   mts_pkg::state_type    state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [1:0]            kind_ff;
   logic [15:0]           err_ff;
   logic                  in_range_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   mts_pkg::rsp_item_type rsp_ff, rsp_in;

   logic                  accept;
   logic                  load_rsp;
   logic [CB-1:0]         n_eff;
   logic [PB-1:0]         prim;
   logic [PB-1:0]         start;
   logic [PB-1:0]         start_next;
   logic                  req_in_range;
   logic [TIME_BITS+31:0] ts_wide;
   logic [TIME_BITS-1:0]  ts_cut;
   mts_pkg::wr_ctl_type   wr;

   mts_pkg::chain_ctl_type chain_ctl [0:PATH_LIMIT];
   logic [TIME_BITS-1:0]   chain_t1  [0:PATH_LIMIT];
   logic [TIME_BITS-1:0]   chain_t2  [0:PATH_LIMIT];
   logic                   cell_act  [0:PATH_LIMIT-1];
   logic [7:0]             act_all;

   // effective path count, primary and round-robin start
   always_comb begin
      if (path_count_ff == '0) begin
         n_eff = CB'(1);
      end else if (path_count_ff > CB'(PATH_LIMIT)) begin
         n_eff = CB'(PATH_LIMIT);
      end else begin
         n_eff = path_count_ff;
      end
      prim  = ({1'b0, primary_ff} < n_eff) ? primary_ff : PB'(n_eff - CB'(1));
      start = ({1'b0, last_shut_ff} < n_eff) ? last_shut_ff : PB'(n_eff - CB'(1));
      start_next = (({1'b0, start} + CB'(1)) == n_eff) ? '0 : PB'(start + PB'(1));
   end

   assign req_in_range = ({1'b0, req_data.path_index} < n_eff);
   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != mts_pkg::ST_IDLE);

   // fit the timestamp to the stored time width
   assign ts_wide = {{TIME_BITS{1'b0}}, req_data.timestamp};
   assign ts_cut  = ts_wide[TIME_BITS-1:0];

   // write the table entry on the accepting edge; choose requests leave it alone
   always_comb begin
      wr.en       = accept && (req_data.req_type != mts_pkg::REQ_CHOOSE) && req_in_range;
      wr.idx      = req_data.path_index;
      wr.set_time = (req_data.req_type == mts_pkg::REQ_HEARD);
      wr.set_act  = (req_data.req_type == mts_pkg::REQ_UP) ||
                    (req_data.req_type == mts_pkg::REQ_DOWN);
      wr.act      = (req_data.req_type == mts_pkg::REQ_UP);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         path_count_ff <= CB'(1);
         primary_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mts_pkg::CSR_PATH_COUNT: path_count_ff <= csr_wdata;
            mts_pkg::CSR_PRIMARY:    primary_ff    <= csr_wdata[PB-1:0];
            default: ;
         endcase
      end
   end

   // cell row: an empty pick enters at the left, results leave at the right
   assign chain_ctl[0] = '0;
   assign chain_t1[0]  = '0;
   assign chain_t2[0]  = '0;

   for (genvar i = 0; i < PATH_LIMIT; i++) begin : g_cell
      mts_cell #(
         .TIME_BITS  (TIME_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr         (wr),
         .wr_time    (ts_cut),
         .path_n     (n_eff),
         .start      (start),
         .in_ctl     (chain_ctl[i]),
         .in_t1      (chain_t1[i]),
         .in_t2      (chain_t2[i]),
         .out_ctl    (chain_ctl[i+1]),
         .out_t1     (chain_t1[i+1]),
         .out_t2     (chain_t2[i+1]),
         .active_out (cell_act[i])
      );
   end

   always_comb begin
      act_all = '0;
      for (int i = 0; i < PATH_LIMIT; i++) begin
         act_all[i] = cell_act[i];
      end
   end

   // request sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mts_pkg::ST_IDLE;
         cnt_ff        <= '0;
         cur_active_ff <= '0;
         cur_retran_ff <= '0;
         last_shut_ff  <= '0;
         shut_sent_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cur_active_ff <= cur_active_in;
         cur_retran_ff <= cur_retran_in;
         last_shut_ff  <= last_shut_in;
         shut_sent_ff  <= shut_sent_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff     <= req_data.req_type;
         err_ff      <= req_data.error_code;
         in_range_ff <= req_in_range;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      mts_pkg::chain_ctl_type fin;
      logic                   have1;
      logic                   have2;
      logic [PB-1:0]          first;
      logic [PB-1:0]          second;
      logic                   upd;
      logic [PB-1:0]          pick;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cur_active_in = cur_active_ff;
      cur_retran_in = cur_retran_ff;
      last_shut_in  = last_shut_ff;
      shut_sent_in  = shut_sent_ff;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      // final path picks from the right end of the row
      fin    = chain_ctl[PATH_LIMIT];
      have1  = fin.have1;
      have2  = fin.have2;
      first  = fin.first;
      second = fin.second;
      if (act_all[prim] && (!have1 || (first != prim))) begin
         second = first;
         have2  = have1;
         first  = prim;
         have1  = 1'b1;
      end
      if (!have1) begin
         first  = prim;
         second = prim;
         have2  = 1'b1;
      end
      if (!have2) begin
         second = first;
      end

      // shutdown pick: active path if none sent, else after start, else wrapped, else start_next
      if (!shut_sent_ff) begin
         pick = cur_active_ff;
      end else if (fin.found_after) begin
         pick = fin.idx_after;
      end else if (fin.found_wrap) begin
         pick = fin.idx_wrap;
      end else begin
         pick = start_next;
      end

      upd = in_range_ff && ((kind_ff == mts_pkg::REQ_UP) || (kind_ff == mts_pkg::REQ_DOWN));

      rsp_in.tx_path       = upd ? first : cur_active_ff;
      rsp_in.rtx_path      = upd ? second : cur_retran_ff;
      rsp_in.shutdown_path = (kind_ff == mts_pkg::REQ_CHOOSE) ? pick : '0;
      rsp_in.notice_kind   = !upd ? mts_pkg::NOTICE_NONE :
                             (kind_ff == mts_pkg::REQ_UP) ? mts_pkg::NOTICE_AVAILABLE :
                                                            mts_pkg::NOTICE_UNREACHABLE;
      rsp_in.notice_error  = upd ? err_ff : '0;

      unique case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = mts_pkg::ST_SCAN;
            end
         end
         mts_pkg::ST_SCAN: begin
            // advance until the last cell holds picks built from the updated table
            cnt_in = CNT_BITS'(cnt_ff + CNT_BITS'(1));
            if (cnt_ff == CNT_BITS'(PATH_LIMIT - 1)) begin
               state_in = mts_pkg::ST_FINISH;
            end
         end
         mts_pkg::ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp      = 1'b1;
               rsp_valid_in  = 1'b1;
               cur_active_in = rsp_in.tx_path;
               cur_retran_in = rsp_in.rtx_path;
               if (kind_ff == mts_pkg::REQ_CHOOSE) begin
                  last_shut_in = pick;
                  shut_sent_in = 1'b1;
               end
               state_in = mts_pkg::ST_IDLE;
            end
         end
         default: state_in = mts_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the multipath transport selector, with a tracking model and random traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PATH_LIMIT      = 8;
   localparam int unsigned SETTLE_CYCLES   = PATH_LIMIT + 6;
   localparam int unsigned HOLD_CYCLES     = 160;
   localparam int unsigned WATCHDOG_LIMIT  = 5000;
   localparam int unsigned RANDOM_PHASES   = 10;
   localparam int unsigned ITEMS_PER_PHASE = 90;
   localparam int unsigned PRESSURE_PHASE  = 3;
   localparam int unsigned PRINT_LIMIT     = 100;

   // Receiver pacing patterns
   typedef enum int unsigned {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_TOGGLE
   } flow_mode_type;

   // Tracks the path table, the picks and the shutdown pointer, and holds the
   // responses that the accepted requests should produce, oldest first.
   class path_pick_tracker;
      bit                    path_up [PATH_LIMIT];
      bit [31:0]             heard_at [PATH_LIMIT];
      bit [2:0]              active_pick;
      bit [2:0]              retran_pick;
      bit [2:0]              last_shutdown;
      bit                    shutdown_sent;
      bit [3:0]              count_setting;
      bit [2:0]              primary_setting;
      mts_pkg::rsp_item_type expected_q[$];
      int unsigned           mismatches;
      int unsigned           checked;
      int unsigned           kind_seen [4];

      function new();
         foreach (path_up[i]) begin
            path_up[i]  = 1'b1;
            heard_at[i] = '0;
         end
         active_pick     = '0;
         retran_pick     = '0;
         last_shutdown   = '0;
         shutdown_sent   = 1'b0;
         count_setting   = 4'd1;
         primary_setting = '0;
         mismatches      = 0;
         checked         = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      // Paths in use: a zero count means one, anything above the row size is clamped.
      function int unsigned live_paths();
         int unsigned n;
         n = count_setting;
         if (n == 0) n = 1;
         if (n > PATH_LIMIT) n = PATH_LIMIT;
         return n;
      endfunction

      // Rank active paths by last-heard time, ties keeping the lower index.
      function void repick(int unsigned n);
         int unsigned prim, first, second, i;
         bit          have1, have2;
         prim   = (primary_setting < n) ? primary_setting : n - 1;
         have1  = 1'b0;
         have2  = 1'b0;
         first  = 0;
         second = 0;
         for (i = 0; i < n; i++) begin
            if (!path_up[i]) continue;
            if (!have1 || heard_at[i] > heard_at[first]) begin
               second = first;
               have2  = have1;
               first  = i;
               have1  = 1'b1;
            end else if (!have2 || heard_at[i] > heard_at[second]) begin
               second = i;
               have2  = 1'b1;
            end
         end
         if (path_up[prim] && (!have1 || first != prim)) begin
            second = first;
            have2  = have1;
            first  = prim;
            have1  = 1'b1;
         end
         if (!have1) begin
            first  = prim;
            second = prim;
            have2  = 1'b1;
         end
         if (!have2) second = first;
         active_pick = first[2:0];
         retran_pick = second[2:0];
      endfunction

      // Round-robin after the last shutdown path, itself tried last; before any, the active pick.
      function bit [2:0] shutdown_pick(int unsigned n);
         int unsigned start, k, idx;
         if (!shutdown_sent) return active_pick;
         start = (last_shutdown < n) ? last_shutdown : n - 1;
         for (k = 1; k <= n; k++) begin
            idx = (start + k) % n;
            if (path_up[idx]) return idx[2:0];
         end
         idx = (start + 1) % n;
         return idx[2:0];
      endfunction

      function void note_request(mts_pkg::req_item_type r);
         mts_pkg::rsp_item_type want;
         int unsigned           n;
         n    = live_paths();
         want = '0;
         kind_seen[r.req_type]++;
         if (r.req_type == mts_pkg::REQ_CHOOSE) begin
            want.shutdown_path = shutdown_pick(n);
            last_shutdown      = want.shutdown_path;
            shutdown_sent      = 1'b1;
         end else if (r.path_index < n) begin
            if (r.req_type == mts_pkg::REQ_HEARD) begin
               heard_at[r.path_index] = r.timestamp;
            end else begin
               path_up[r.path_index] = (r.req_type == mts_pkg::REQ_UP);
               if (r.req_type == mts_pkg::REQ_UP)
                  want.notice_kind = mts_pkg::NOTICE_AVAILABLE;
               else
                  want.notice_kind = mts_pkg::NOTICE_UNREACHABLE;
               want.notice_error = r.error_code;
               repick(n);
            end
         end
         want.tx_path  = active_pick;
         want.rtx_path = retran_pick;
         expected_q.push_back(want);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      task check_response(mts_pkg::rsp_item_type got);
         mts_pkg::rsp_item_type want;
         if (expected_q.size() == 0) begin
            report("unexpected response", 32'(got), 32'd0);
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.tx_path !== want.tx_path)
            report("tx_path", 32'(got.tx_path), 32'(want.tx_path));
         if (got.rtx_path !== want.rtx_path)
            report("rtx_path", 32'(got.rtx_path), 32'(want.rtx_path));
         if (got.shutdown_path !== want.shutdown_path)
            report("shutdown_path", 32'(got.shutdown_path), 32'(want.shutdown_path));
         if (got.notice_kind !== want.notice_kind)
            report("notice_kind", 32'(got.notice_kind), 32'(want.notice_kind));
         if (got.notice_error !== want.notice_error)
            report("notice_error", 32'(got.notice_error), 32'(want.notice_error));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   mts_pkg::req_item_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   mts_pkg::rsp_item_type rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_index = mts_pkg::CSR_PATH_COUNT;
   logic [3:0]            csr_wdata = '0;

   path_pick_tracker tracker = new();

   int unsigned burst_left    = 0;
   bit          steady        = 1'b0;
   int unsigned holds_asked   = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned settings_made = 0;
   logic [31:0] tick          = '0;

   multipath_transport_selector u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Offer one request and hold it until the block takes it. The sender works in
   // bursts; between bursts it may drop valid for a random gap, unless a steady stretch
   // is running.
   task automatic send_request(input logic [1:0] kind, input logic [2:0] path,
                               input logic [31:0] stamp, input logic [15:0] code);
      mts_pkg::req_item_type item;
      int unsigned           gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      item.req_type   = kind;
      item.path_index = path;
      item.timestamp  = stamp;
      item.error_code = code;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Accepted at this edge: advance the tracker in acceptance order
      tracker.note_request(item);
      burst_left--;
   endtask

   // Wait for every outstanding response, then let the block settle so that
   // register writes land while it is idle.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (tracker.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges; lower the enable only after the second.
   task automatic apply_settings(input logic [3:0] count, input logic [2:0] prim);
      csr_wr_en <= 1'b1;
      csr_index <= mts_pkg::CSR_PATH_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      csr_index <= mts_pkg::CSR_PRIMARY;
      csr_wdata <= {1'b0, prim};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.count_setting   = count;
      tracker.primary_setting = prim;
      settings_made++;
   endtask

   // Receiver pacing: drive stall in randomly chosen patterns; when a long hold is asked,
   // keep stall high for a fixed stretch so that the block backs up into req_stall.
   initial begin : rsp_pacer
      int unsigned   holds_given;
      int unsigned   cyc;
      flow_mode_type mode;
      holds_given = 0;
      cyc         = 0;
      mode        = FLOW_FREE;
      forever begin
         @(posedge clock);
         if (holds_given != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_given++;
            rsp_stall <= 1'b0;
         end else begin
            if (cyc % 48 == 0) mode = flow_mode_type'($urandom_range(0, 3));
            cyc++;
            case (mode)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Check every response taken at an edge against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_response(rsp_data);
   end

   // Watchdog: give up once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase, i, n, roll;
      logic [1:0]  kind;
      logic [2:0]  path;
      logic [31:0] stamp;
      logic [3:0]  count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: eight paths, primary 0. Extreme times, primary down, first
      // shutdown answering the active path, then round-robin, and a tie in time.
      apply_settings(4'd8, 3'd0);
      send_request(mts_pkg::REQ_HEARD,  3'd0, 32'h0000_0000, 16'hFFFF);
      send_request(mts_pkg::REQ_HEARD,  3'd7, 32'hFFFF_FFFF, 16'h0000);
      send_request(mts_pkg::REQ_HEARD,  3'd3, 32'h8000_0000, 16'h1234);
      send_request(mts_pkg::REQ_DOWN,   3'd0, 32'h0000_0000, 16'hFFFF);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_CHOOSE, 3'd5, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(mts_pkg::REQ_UP,     3'd0, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_HEARD,  3'd5, 32'hFFFF_FFFF, 16'h0000);
      send_request(mts_pkg::REQ_UP,     3'd5, 32'h0000_0000, 16'h5A5A);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);

      // Three paths with primary 7 (clamps to 2): stale shutdown pointer,
      // out-of-range path indexes, every path down, then a lone active path.
      drain_responses();
      apply_settings(4'd3, 3'd7);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_HEARD,  3'd6, 32'h1234_5678, 16'h0000);
      send_request(mts_pkg::REQ_DOWN,   3'd7, 32'h0000_0000, 16'h1111);
      send_request(mts_pkg::REQ_DOWN,   3'd2, 32'h0000_0000, 16'h2222);
      send_request(mts_pkg::REQ_DOWN,   3'd0, 32'h0000_0000, 16'h3333);
      send_request(mts_pkg::REQ_DOWN,   3'd1, 32'h0000_0000, 16'h4444);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_UP,     3'd1, 32'h0000_0000, 16'hAAAA);

      // A zero count behaves as one path
      drain_responses();
      apply_settings(4'd0, 3'd0);
      send_request(mts_pkg::REQ_UP,     3'd0, 32'h0000_0000, 16'hFFFF);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);

      // Largest count clamps to eight; primary at the top index
      drain_responses();
      apply_settings(4'd15, 3'd7);
      send_request(mts_pkg::REQ_DOWN,   3'd7, 32'h0000_0000, 16'h0000);
      send_request(mts_pkg::REQ_UP,     3'd7, 32'h0000_0000, 16'hFFFF);
      send_request(mts_pkg::REQ_CHOOSE, 3'd0, 32'h0000_0000, 16'h0000);

      // Random phases: fresh settings each time, mostly in-range paths, timestamps
      // that mix full-range values, tiny values that tie, a rising clock and extremes.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_responses();
         if (phase == 0)
            count = 4'd8;
         else if ($urandom_range(0, 3) == 0)
            count = 4'($urandom_range(0, 15));
         else
            count = 4'($urandom_range(2, 8));
         apply_settings(count, 3'($urandom_range(0, 7)));
         if (phase == PRESSURE_PHASE) begin
            // Keep offering with no gaps while the receiver holds off
            steady = 1'b1;
            holds_asked++;
         end
         n = tracker.live_paths();
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
               kind = mts_pkg::REQ_HEARD;
            else if (roll < 60)
               kind = mts_pkg::REQ_UP;
            else if (roll < 82)
               kind = mts_pkg::REQ_DOWN;
            else
               kind = mts_pkg::REQ_CHOOSE;
            if ($urandom_range(0, 9) == 0)
               path = 3'($urandom_range(0, 7));
            else
               path = 3'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
               0: stamp = $urandom();
               1: stamp = $urandom_range(0, 3);
               2: begin
                  tick  = tick + $urandom_range(1, 100);
                  stamp = tick;
               end
               default: stamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            endcase
            send_request(kind, path, stamp, 16'($urandom_range(0, 16'hFFFF)));
         end
         steady = 1'b0;
      end

      drain_responses();
      if (tracker.expected_q.size() != 0)
         tracker.report("responses left outstanding", 32'(tracker.expected_q.size()), 32'd0);

      $display("Covered %0d requests (heard %0d, up %0d, down %0d, choose %0d), %0d settings",
               tracker.kind_seen[mts_pkg::REQ_HEARD] + tracker.kind_seen[mts_pkg::REQ_UP]
               + tracker.kind_seen[mts_pkg::REQ_DOWN] + tracker.kind_seen[mts_pkg::REQ_CHOOSE],
               tracker.kind_seen[mts_pkg::REQ_HEARD], tracker.kind_seen[mts_pkg::REQ_UP],
               tracker.kind_seen[mts_pkg::REQ_DOWN], tracker.kind_seen[mts_pkg::REQ_CHOOSE],
               settings_made);
      $display("Responses checked: %0d, mismatches: %0d", tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/multipath_transport_selector.sv
bench/testbench.sv
